/* hdl/jdm_pkg.sv */
// Shared types and constants for the joystick drive mixer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jdm_pkg;

   localparam int unsigned RAW_W     = 12;
   localparam int unsigned CSR_W     = 12;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned POS_W     = 13;
   localparam int unsigned DUTY_W    = 13;
   localparam int unsigned CASE_W    = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP      = 1'b1;

   localparam logic [CSR_W-1:0] DEAD_ZONE_RST = 12'd400;
   localparam logic [CSR_W-1:0] SNAP_RST      = 12'd3900;

   // 2*raw+1 minus this gives 2*raw-4095
   localparam logic [RAW_W:0] RAW_MID = 13'd4096;

   localparam int unsigned IDLE_BAND     = 20;
   localparam int unsigned STRAIGHT_BAND = 10;

   localparam logic [CASE_W-1:0] CASE_IDLE       = 5'd0;
   localparam logic [CASE_W-1:0] CASE_FWD        = 5'd1;
   localparam logic [CASE_W-1:0] CASE_BACK       = 5'd2;
   localparam logic [CASE_W-1:0] CASE_SPOT_LEFT  = 5'd3;
   localparam logic [CASE_W-1:0] CASE_SPOT_RIGHT = 5'd4;
   localparam logic [CASE_W-1:0] CASE_OCT_BASE   = 5'd5;
   localparam logic [CASE_W-1:0] CASE_LAST       = 5'd20;
   localparam int unsigned       CASE_COUNT      = 21;

   // Direction bits and per-side duty selectors: |FS*o - a*|x| - b*|y||
   typedef struct packed {
      logic left_dir;
      logic right_dir;
      logic left_o;
      logic left_a;
      logic left_b;
      logic right_o;
      logic right_a;
      logic right_b;
   } drive_sel_type;

   localparam drive_sel_type CASE_TABLE [0:CASE_COUNT-1] = '{
      8'b00000000,                 // idle
      8'b11001001,                 // forward
      8'b00001001,                 // backward
      8'b01010010,                 // spot left
      8'b10010010,                 // spot right
      8'b10101010, 8'b10010101,    // octant 1 inner, outer
      8'b11110001, 8'b11001110,    // octant 2
      8'b11001110, 8'b11110001,    // octant 3
      8'b01010101, 8'b01101010,    // octant 4
      8'b01101010, 8'b01010101,    // octant 5
      8'b00110001, 8'b00001110,    // octant 6
      8'b00001110, 8'b00110001,    // octant 7
      8'b10010101, 8'b10101010     // octant 8
   };

endpackage

/* hdl/joystick_drive_mixer_top.sv */
// An accepted request is held in the input register, passes the mapping and case
// logic, then loads the response register. Throughput: one transaction per cycle
// while rsp_ready holds; stalls are held in both registers.
// Reset (synchronous, active high) empties both stages and restores
// dead_zone to 400 and snap_threshold to 3900. Depends on jdm_pkg, jdm_axis_map.
`timescale 1ns / 1ps

module joystick_drive_mixer_top import jdm_pkg::*; #(
   parameter int unsigned FULL_SCALE = 4095
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [RAW_W-1:0]        req_x_raw,
   input  logic [RAW_W-1:0]        req_y_raw,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_left_on,
   output logic                    rsp_right_on,
   output logic [DUTY_W-1:0]       rsp_left_duty,
   output logic [DUTY_W-1:0]       rsp_right_duty,
   output logic [CASE_W-1:0]       rsp_drive_case,
   output logic signed [POS_W-1:0] rsp_x_pos,
   output logic signed [POS_W-1:0] rsp_y_pos
);

   localparam int unsigned FS_W  = $clog2(FULL_SCALE + 1);
   localparam int unsigned MAG_W = (FS_W > RAW_W) ? FS_W : RAW_W;
   localparam int unsigned DW    = MAG_W + 2;

   logic [CSR_W-1:0] dead_zone_ff, snap_ff;
   logic             stg_valid_ff, stg_valid_in;
   logic [RAW_W-1:0] x_raw_ff, y_raw_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_load;

   logic                left_on_ff, right_on_ff;
   logic [DUTY_W-1:0]   left_duty_ff, right_duty_ff;
   logic [CASE_W-1:0]   case_ff;
   logic [POS_W-1:0]    x_pos_ff, y_pos_ff;

   logic signed [MAG_W:0] x_pos, y_pos;
   logic [MAG_W-1:0]      ax, ay;
   logic                  x_neg, x_pos_gt, y_neg, y_pos_gt;
   logic [MAG_W:0]        mag_sum;
   logic                  outer;
   logic [2:0]            oct_idx;
   logic [CASE_W-1:0]     drive_case;
   drive_sel_type         sel;
   logic [DUTY_W-1:0]     left_duty, right_duty;

   function automatic logic [DUTY_W-1:0] duty_f(input logic o, input logic a, input logic b,
                                                 input logic [MAG_W-1:0] mx,
                                                 input logic [MAG_W-1:0] my);
      logic [DW-1:0] v;
      logic [DW-1:0] m;
      v = (o ? DW'(FULL_SCALE) : DW'(0)) - (a ? DW'(mx) : DW'(0)) - (b ? DW'(my) : DW'(0));
      m = v[DW-1] ? -v : v;
      return m[DUTY_W-1:0];
   endfunction

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RST;
         snap_ff      <= SNAP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEAD_ZONE: dead_zone_ff <= csr_wdata;
            CSR_SNAP:      snap_ff      <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Handshake
   assign out_load     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !stg_valid_ff || out_load;
   assign stg_valid_in = req_ready ? req_valid : stg_valid_ff;
   assign rsp_valid_in = out_load ? stg_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_raw_ff <= req_x_raw;
         y_raw_ff <= req_y_raw;
      end
   end

   jdm_axis_map #(.FULL_SCALE(FULL_SCALE), .MAG_W(MAG_W)) u_map_x (
      .raw            (x_raw_ff),
      .dead_zone      (dead_zone_ff),
      .snap_threshold (snap_ff),
      .pos            (x_pos),
      .pos_mag        (ax)
   );

   jdm_axis_map #(.FULL_SCALE(FULL_SCALE), .MAG_W(MAG_W)) u_map_y (
      .raw            (y_raw_ff),
      .dead_zone      (dead_zone_ff),
      .snap_threshold (snap_ff),
      .pos            (y_pos),
      .pos_mag        (ay)
   );

   // Case selection
   always_comb begin
      x_neg    = x_pos[MAG_W];
      y_neg    = y_pos[MAG_W];
      x_pos_gt = !x_neg && (ax != '0);
      y_pos_gt = !y_neg && (ay != '0);
      mag_sum  = {1'b0, ax} + {1'b0, ay};
      outer    = (mag_sum > (MAG_W + 1)'(FULL_SCALE));
      oct_idx  = 3'd0;

      priority if (ax < MAG_W'(IDLE_BAND) && ay < MAG_W'(IDLE_BAND)) begin
         drive_case = CASE_IDLE;
      end else if (ax < MAG_W'(STRAIGHT_BAND) && y_neg) begin
         drive_case = CASE_FWD;
      end else if (ax < MAG_W'(STRAIGHT_BAND) && y_pos_gt) begin
         drive_case = CASE_BACK;
      end else if (x_neg && ay <= MAG_W'(IDLE_BAND)) begin
         drive_case = CASE_SPOT_LEFT;
      end else if (x_pos_gt && ay <= MAG_W'(IDLE_BAND)) begin
         drive_case = CASE_SPOT_RIGHT;
      end else if (x_pos_gt && y_neg) begin
         oct_idx    = (ax >= ay) ? 3'd0 : 3'd1;
         drive_case = CASE_OCT_BASE + {1'b0, oct_idx, outer};
      end else if (x_neg && y_neg) begin
         oct_idx    = (ay > ax) ? 3'd2 : 3'd3;
         drive_case = CASE_OCT_BASE + {1'b0, oct_idx, outer};
      end else if (x_neg && y_pos_gt) begin
         oct_idx    = (ax > ay) ? 3'd4 : 3'd5;
         drive_case = CASE_OCT_BASE + {1'b0, oct_idx, outer};
      end else if (x_pos_gt && y_pos_gt) begin
         oct_idx    = (ay >= ax) ? 3'd6 : 3'd7;
         drive_case = CASE_OCT_BASE + {1'b0, oct_idx, outer};
      end else begin
         drive_case = CASE_IDLE;
      end

      sel        = CASE_TABLE[drive_case];
      left_duty  = duty_f(sel.left_o, sel.left_a, sel.left_b, ax, ay);
      right_duty = duty_f(sel.right_o, sel.right_a, sel.right_b, ax, ay);
   end

   always_ff @(posedge clock) begin
      if (out_load && stg_valid_ff) begin
         left_on_ff    <= sel.left_dir;
         right_on_ff   <= sel.right_dir;
         left_duty_ff  <= left_duty;
         right_duty_ff <= right_duty;
         case_ff       <= drive_case;
         x_pos_ff      <= x_pos[POS_W-1:0];
         y_pos_ff      <= y_pos[POS_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_on    = left_on_ff;
   assign rsp_right_on   = right_on_ff;
   assign rsp_left_duty  = left_duty_ff;
   assign rsp_right_duty = right_duty_ff;
   assign rsp_drive_case = case_ff;
   assign rsp_x_pos      = $signed(x_pos_ff);
   assign rsp_y_pos      = $signed(y_pos_ff);

endmodule

/* hdl/jdm_axis_map.sv */
// Maps one raw converter sample to a signed position with dead zone and snap.
// Depends on jdm_pkg.
`timescale 1ns / 1ps

module jdm_axis_map import jdm_pkg::*; #(
   parameter int unsigned FULL_SCALE = 4095,
   parameter int unsigned MAG_W      = 12
) (
   input  logic [RAW_W-1:0]       raw,
   input  logic [CSR_W-1:0]       dead_zone,
   input  logic [CSR_W-1:0]       snap_threshold,
   output logic signed [MAG_W:0]  pos,
   output logic [MAG_W-1:0]       pos_mag
);

   logic [RAW_W:0]   twice_p1;
   logic             neg;
   logic [RAW_W-1:0] raw_mag;

   always_comb begin
      twice_p1 = {raw, 1'b1};
      neg      = ~raw[RAW_W-1];
      if (neg) begin
         raw_mag = RAW_W'(RAW_MID - twice_p1);
      end else begin
         raw_mag = RAW_W'(twice_p1 - RAW_MID);
      end

      if (raw_mag < dead_zone) begin
         pos_mag = '0;
      end else if (raw_mag > snap_threshold) begin
         pos_mag = MAG_W'(FULL_SCALE);
      end else begin
         pos_mag = MAG_W'(raw_mag);
      end

      if (neg) begin
         pos = -$signed({1'b0, pos_mag});
      end else begin
         pos = $signed({1'b0, pos_mag});
      end
   end

endmodule

/* hdl/jdm_checker.sv */
// Port-level checks for joystick_drive_mixer_top, attached by bind.
// Depends on jdm_pkg and the top level's port list.
`timescale 1ns / 1ps

module jdm_checker import jdm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_left_on,
   input logic                    rsp_right_on,
   input logic [DUTY_W-1:0]       rsp_left_duty,
   input logic [DUTY_W-1:0]       rsp_right_duty,
   input logic [CASE_W-1:0]       rsp_drive_case,
   input logic signed [POS_W-1:0] rsp_x_pos,
   input logic signed [POS_W-1:0] rsp_y_pos
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_case)
         && $stable(rsp_left_duty) && $stable(rsp_right_duty) && $stable(rsp_x_pos)
         && $stable(rsp_y_pos))
      else $error("stalled response changed");

   a_case_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_case <= CASE_LAST)
      else $error("drive case out of range");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_case == CASE_IDLE |->
         !rsp_left_on && !rsp_right_on && rsp_left_duty == '0 && rsp_right_duty == '0)
      else $error("idle case drives outputs");

   a_fwd_both_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_case == CASE_FWD |-> rsp_left_on && rsp_right_on)
      else $error("forward case without both directions on");

endmodule

bind joystick_drive_mixer_top jdm_checker u_jdm_checker (.*);
